@@ rtl/xorshift128_ranged_generator_assert.svh @@
// Assertion macros for the xorshift128 ranged generator.
// Each macro checks one implication on i_clk, with i_rst_n low masking the check.
`ifndef XORSHIFT128_RANGED_GENERATOR_ASSERT_SVH
`define XORSHIFT128_RANGED_GENERATOR_ASSERT_SVH

// same-cycle implication
`define XS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/xs128_pkg.sv @@
// Shared types, constants and the xorshift128 step function.
// Used by xs128_divider and xorshift128_ranged_generator; no dependencies.
`timescale 1ns / 1ps
package xs128_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);
    localparam int unsigned CFG_W  = 3;

    localparam int unsigned SHIFT_A = 11;
    localparam int unsigned SHIFT_B = 8;
    localparam int unsigned SHIFT_C = 19;

    localparam logic [WORD_W-1:0] SEED0_RST = 32'd123456789;
    localparam logic [WORD_W-1:0] SEED1_RST = 32'd362436069;
    localparam logic [WORD_W-1:0] SEED2_RST = 32'd521288629;
    localparam logic [WORD_W-1:0] SEED3_RST = 32'd88675123;

    localparam logic [CFG_W-1:0] CFG_SEED0 = 3'd0;
    localparam logic [CFG_W-1:0] CFG_SEED1 = 3'd1;
    localparam logic [CFG_W-1:0] CFG_SEED2 = 3'd2;
    localparam logic [CFG_W-1:0] CFG_SEED3 = 3'd3;

    typedef enum logic [1:0] {
        KIND_RAW    = 2'd0,
        KIND_RANGE  = 2'd1,
        KIND_RESEED = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] oldest,
                                                  input logic [WORD_W-1:0] newest);
        logic [WORD_W-1:0] t;
        t = oldest ^ (oldest << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        return t ^ newest ^ (newest >> SHIFT_C);
    endfunction

endpackage

@@ rtl/xs128_divider.sv @@
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on xs128_pkg for widths and the status struct.
`timescale 1ns / 1ps
module xs128_divider import xs128_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output t_div_status       o_status,
    output logic [WORD_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_div;

    logic [WORD_W:0]   w_trial;
    logic [WORD_W:0]   w_diff;
    logic [WORD_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[WORD_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = w_diff[WORD_W] ? w_trial[WORD_W-1:0] : w_diff[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[WORD_W-2:0], 1'b0};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

@@ rtl/xorshift128_ranged_generator.sv @@
// A raw draw goes idle, step, done; a ranged draw adds the divide state (skipped if the span
// wraps), where the bit-serial remainder unit takes one bit per cycle over 32 bits. Requests
// are taken only in idle, so a new draw waits until the last leaves done; a reseed stays idle.
// Reset (synchronous, active low) loads seed registers and state with the seed defaults.
// Top level: xorshift128 state, request sequencer, output register.
// Depends on xs128_pkg, xs128_divider and the assertion macro header.
`timescale 1ns / 1ps
`include "xorshift128_ranged_generator_assert.svh"
module xorshift128_ranged_generator import xs128_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [WORD_W-1:0] i_range_low,
    input  logic [WORD_W-1:0] i_range_high,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data
);

    t_state                  r_state;
    t_state                  n_state;
    logic [3:0][WORD_W-1:0]  r_seed;
    logic [3:0][WORD_W-1:0]  r_gen;
    logic [1:0]              r_kind;
    logic [WORD_W-1:0]       r_low;
    logic [WORD_W-1:0]       r_span;
    logic [WORD_W-1:0]       r_res;
    logic                    r_out_valid;
    logic [WORD_W-1:0]       r_out_value;

    logic                    w_in_xfer;
    logic                    w_draw_xfer;
    logic                    w_step;
    logic                    w_div_start;
    logic                    w_out_load;
    logic [WORD_W-1:0]       w_word;
    t_div_status             w_div_status;
    logic [WORD_W-1:0]       w_div_rem;

    assign w_in_xfer   = i_valid && o_ready;
    assign w_draw_xfer = w_in_xfer && (i_kind == KIND_RAW || i_kind == KIND_RANGE);
    assign w_word      = xs_next(r_gen[3], r_gen[0]);

    xs128_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_word),
        .i_divisor  (r_span),
        .o_status   (w_div_status),
        .o_rem      (w_div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_draw_xfer) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_kind == KIND_RANGE && r_span != '0) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_status.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready     = 1'b0;
        w_step      = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_STEP: begin
                w_step      = 1'b1;
                w_div_start = (r_kind == KIND_RANGE) && (r_span != '0);
            end
            ST_DIV:  w_out_load = 1'b0;
            ST_DONE: w_out_load = !r_out_valid || i_ready;
            default: o_ready = 1'b0;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_seed      <= {SEED3_RST, SEED2_RST, SEED1_RST, SEED0_RST};
            r_gen       <= {SEED3_RST, SEED2_RST, SEED1_RST, SEED0_RST};
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SEED0: r_seed[0] <= i_cfg_data;
                    CFG_SEED1: r_seed[1] <= i_cfg_data;
                    CFG_SEED2: r_seed[2] <= i_cfg_data;
                    CFG_SEED3: r_seed[3] <= i_cfg_data;
                    default:   r_seed    <= r_seed;
                endcase
            end
            // reseed on transfer, advance in the step state
            if (w_in_xfer && i_kind == KIND_RESEED) begin
                r_gen <= r_seed;
            end else if (w_step) begin
                r_gen <= {r_gen[2], r_gen[1], r_gen[0], w_word};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_kind <= i_kind;
            r_low  <= i_range_low;
            r_span <= i_range_high - i_range_low + 1'b1;
        end
        if (w_step) begin
            r_res <= w_word;
        end else if (w_div_status.done) begin
            r_res <= w_div_rem + r_low;
        end
        if (w_out_load) begin
            r_out_value <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    `XS_ASSERT_NEXT(a_draw_steps, w_draw_xfer, r_state == ST_STEP, "draw did not step")
    `XS_ASSERT_NOW(a_div_active, r_state == ST_DIV, |w_div_status, "divider idle")
    `XS_ASSERT_NEXT(a_gen_hold, r_state == ST_DIV, $stable(r_gen), "state moved in divide")
    `XS_ASSERT_NOW(a_out_src, $rose(r_out_valid), $past(r_state == ST_DONE), "stray result")

endmodule
